// File: hdl/slc_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
package slc_pkg;

   // Field widths
   localparam int TAG_W     = 32;
   localparam int ADDR_W    = 32;
   localparam int CNT_W     = 32;
   localparam int RANK_W    = 3;
   localparam int SLOT_W    = RANK_W + 1;   // valid bit over the rank
   localparam int RAW_IDX_W = 15;           // widest set index a 4-bit index_bits allows

   // Rank codes
   localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
   localparam logic [RANK_W-1:0] RANK_NEW = 3'd1;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED   = 2'd2;
   localparam int CSR_DATA_W = 4;

   // Configuration reset values
   localparam logic [3:0] OFFSET_BITS_RST = 4'd5;
   localparam logic [3:0] INDEX_BITS_RST  = 4'd8;
   localparam logic [2:0] WAYS_USED_RST   = 3'd4;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [3:0] index_bits;
      logic [2:0] ways_used;
   } cfg_type;

endpackage

// File: hdl/slc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/slc_fifo.sv
// Short register queue between the address front end and the directory back end.
module slc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/slc_front.sv
// Front end: takes an address beat and splits it into set index and tag.
module slc_front import slc_pkg::*; #(
   parameter int SETS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfg_type                              cfg,
   input  logic                                 hold,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ADDR_W-1:0]                    req_address,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] push_set,
   output logic [TAG_W-1:0]                     push_tag
);

   localparam int SET_W  = SETS > 1 ? $clog2(SETS) : 1;
   localparam int PROD_W = RAW_IDX_W + 33;
   // floor(2^32 / SETS): quotient estimate is exact or one short
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SETS);

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic [RAW_IDX_W-1:0] raw_ff, raw_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [RAW_IDX_W-1:0] quot_ff, quot_in;

   logic                 accept;
   logic [RAW_IDX_W:0]   mask_w;
   logic [4:0]           tag_sh_w;
   logic [PROD_W-1:0]    prod_w;
   logic [32:0]          qs_w;
   logic [32:0]          rem_w;
   logic [32:0]          rem_fix_w;

   assign req_ready = !busy_ff && !hold;
   assign accept    = req_valid && req_ready;

   // Address split
   assign mask_w   = ((RAW_IDX_W + 1)'(1) << cfg.index_bits) - (RAW_IDX_W + 1)'(1);
   assign tag_sh_w = 5'(cfg.offset_bits) + 5'(cfg.index_bits);

   // Set index modulo SETS: reciprocal multiply, then one correction
   assign prod_w    = PROD_W'(raw_ff) * PROD_W'(RECIP);
   assign qs_w      = 33'(quot_ff) * 33'(SETS);
   assign rem_w     = 33'(raw_ff) - qs_w;
   assign rem_fix_w = (rem_w >= 33'(SETS)) ? rem_w - 33'(SETS) : rem_w;

   assign push_valid = busy_ff && phase_ff;
   assign push_set   = rem_fix_w[SET_W-1:0];
   assign push_tag   = tag_ff;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      raw_in   = raw_ff;
      tag_in   = tag_ff;
      quot_in  = quot_ff;
      if (accept) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         raw_in   = RAW_IDX_W'(req_address >> cfg.offset_bits) & mask_w[RAW_IDX_W-1:0];
         tag_in   = req_address >> tag_sh_w;
      end else if (busy_ff && !phase_ff) begin
         quot_in  = prod_w[32 +: RAW_IDX_W];
         phase_in = 1'b1;
      end else if (push_valid && push_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      tag_ff  <= tag_in;
      quot_ff <= quot_in;
   end

endmodule

// File: hdl/slc_back.sv
// Back end: set read, way search, LRU rank update and hit/miss counters.
module slc_back import slc_pkg::*; #(
   parameter int SETS = 256,
   parameter int WAYS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfg_type                              cfg,
   output logic                                 clearing,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] pop_set,
   input  logic [TAG_W-1:0]                     pop_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_was_hit,
   output logic [CNT_W-1:0]                     rsp_hit_count,
   output logic [CNT_W-1:0]                     rsp_miss_count
);

   localparam int SET_W  = SETS > 1 ? $clog2(SETS) : 1;
   localparam int WW     = WAYS > 1 ? $clog2(WAYS) : 1;
   localparam int STAT_W = WAYS * SLOT_W;
   localparam int TROW_W = WAYS * TAG_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOK   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [SET_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              hit_ff, hit_in;
   logic [WW-1:0]     way_ff, way_in;
   logic [RANK_W-1:0] old_rank_ff, old_rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              was_hit_ff, was_hit_in;
   logic [CNT_W-1:0]  hits_ff, hits_in;
   logic [CNT_W-1:0]  misses_ff, misses_in;

   logic              rd_en;
   logic [STAT_W-1:0] stat_rd, stat_wr;
   logic [TROW_W-1:0] tag_rd, tag_wr;
   logic              stat_we, tag_we;
   logic [SET_W-1:0]  stat_wr_addr;

   logic [WAYS-1:0]   act_w;
   logic              hit_w, inv_w;
   logic [WW-1:0]     hit_way_w, inv_way_w, vic_w;
   logic [RANK_W-1:0] best_w, old_w;
   logic              do_update;

   assign clearing  = state_ff == ST_CLEAR;
   assign rd_en     = (state_ff == ST_IDLE) && pop_valid;
   assign pop_ready = rd_en;
   assign do_update = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   // Valid bit and rank per way; cleared by the pass after reset
   slc_ram #(.WIDTH(STAT_W), .DEPTH(SETS)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (stat_wr_addr),
      .wr_data (stat_wr),
      .rd_en   (rd_en),
      .rd_addr (pop_set),
      .rd_data (stat_rd)
   );

   // Tags per way; only read behind a valid bit
   slc_ram #(.WIDTH(TROW_W), .DEPTH(SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (set_ff),
      .wr_data (tag_wr),
      .rd_en   (rd_en),
      .rd_addr (pop_set),
      .rd_data (tag_rd)
   );

   // Ways in use: ways_used of zero acts as one
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         act_w[w] = (w == 0) || (w < int'(cfg.ways_used));
      end
   end

   // Way search: lowest hit, highest invalid, highest-ranked victim
   always_comb begin
      hit_w     = 1'b0;
      hit_way_w = '0;
      old_w     = '0;
      inv_w     = 1'b0;
      inv_way_w = '0;
      best_w    = '0;
      vic_w     = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (act_w[w]) begin
            if (!hit_w && stat_rd[w*SLOT_W + RANK_W] && tag_rd[w*TAG_W +: TAG_W] == tag_ff) begin
               hit_w     = 1'b1;
               hit_way_w = WW'(w);
               old_w     = stat_rd[w*SLOT_W +: RANK_W];
            end
            if (!stat_rd[w*SLOT_W + RANK_W]) begin
               inv_w     = 1'b1;
               inv_way_w = WW'(w);
            end
            if (stat_rd[w*SLOT_W +: RANK_W] >= best_w) begin
               best_w = stat_rd[w*SLOT_W +: RANK_W];
               vic_w  = WW'(w);
            end
         end
      end
   end

   // Chosen way to rank one; others age, but on a hit only lower ones
   always_comb begin
      stat_wr = stat_rd;
      tag_wr  = tag_rd;
      for (int w = 0; w < WAYS; w++) begin
         if (act_w[w]) begin
            if (WW'(w) == way_ff) begin
               stat_wr[w*SLOT_W +: SLOT_W] = {1'b1, RANK_NEW};
               tag_wr[w*TAG_W +: TAG_W]    = tag_ff;
            end else if (stat_rd[w*SLOT_W + RANK_W] &&
                         (!hit_ff || stat_rd[w*SLOT_W +: RANK_W] < old_rank_ff)) begin
               if (stat_rd[w*SLOT_W +: RANK_W] != RANK_MAX) begin
                  stat_wr[w*SLOT_W +: RANK_W] = stat_rd[w*SLOT_W +: RANK_W] + RANK_W'(1);
               end
            end
         end
      end
      if (clearing) begin
         stat_wr = '0;
      end
   end

   assign stat_we      = clearing || do_update;
   assign stat_wr_addr = clearing ? clr_addr_ff : set_ff;
   assign tag_we       = do_update && !hit_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      hit_in       = hit_ff;
      way_in       = way_ff;
      old_rank_in  = old_rank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      was_hit_in   = was_hit_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == SET_W'(SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + SET_W'(1);
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               set_in   = pop_set;
               tag_in   = pop_tag;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hit_in      = hit_w;
            way_in      = hit_w ? hit_way_w : (inv_w ? inv_way_w : vic_w);
            old_rank_in = old_w;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (do_update) begin
               rsp_valid_in = 1'b1;
               was_hit_in   = hit_ff;
               if (hit_ff) begin
                  if (hits_ff != '1) hits_in = hits_ff + CNT_W'(1);
               end else begin
                  if (misses_ff != '1) misses_in = misses_ff + CNT_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      hit_ff      <= hit_in;
      way_ff      <= way_in;
      old_rank_ff <= old_rank_in;
      was_hit_ff  <= was_hit_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_was_hit    = was_hit_ff;
   assign rsp_hit_count  = hits_ff;
   assign rsp_miss_count = misses_ff;

endmodule

// File: hdl/set_assoc_lru_cache_model.sv
// Set-associative cache directory with rank-based LRU that counts hits and
// misses of a stream of read addresses; no line data is kept. Each address
// beat is split into set index and tag by the front end, which reduces the
// index modulo SETS by a registered reciprocal multiply, and queued; the back
// end then does a read-modify-write of one set row in the valid/rank and tag
// memories: pop and read, search the ways, write back and load the result
// register. Neither end takes a new beat before it is done with the last,
// and the back end holds its write back while a result is not taken. After
// reset a clearing pass zeroes the valid/rank memory; no request beat is
// taken until it ends. Configuration writes take effect at once and are
// meant to be made while the block is idle.
module set_assoc_lru_cache_model import slc_pkg::*; #(
   parameter int SETS = 256,
   parameter int WAYS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_was_hit,
   output logic [CNT_W-1:0]      rsp_hit_count,
   output logic [CNT_W-1:0]      rsp_miss_count
);

   localparam int SET_W = SETS > 1 ? $clog2(SETS) : 1;

   cfg_type          cfg_ff, cfg_in;
   logic             clearing;
   logic             push_valid, push_ready;
   logic [SET_W-1:0] push_set;
   logic [TAG_W-1:0] push_tag;
   logic             pop_valid, pop_ready;
   logic [SET_W-1:0] pop_set;
   logic [TAG_W-1:0] pop_tag;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_OFFSET_BITS: cfg_in.offset_bits = csr_wdata;
            CSR_INDEX_BITS:  cfg_in.index_bits  = csr_wdata;
            CSR_WAYS_USED:   cfg_in.ways_used   = csr_wdata[2:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= OFFSET_BITS_RST;
         cfg_ff.index_bits  <= INDEX_BITS_RST;
         cfg_ff.ways_used   <= WAYS_USED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slc_front #(.SETS(SETS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .hold        (clearing),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_set    (push_set),
      .push_tag    (push_tag)
   );

   slc_fifo #(.WIDTH(SET_W + TAG_W), .DEPTH(2)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_set, push_tag}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   ({pop_set, pop_tag})
   );

   slc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .clearing       (clearing),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_set        (pop_set),
      .pop_tag        (pop_tag),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_was_hit    (rsp_was_hit),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_miss_count (rsp_miss_count)
   );

endmodule
